FILE: rtl/core/tssa_pkg.sv
package tssa_pkg;

	localparam int NEURONS    = 64;
	localparam int IDX_W      = 6;
	localparam int SUM_W      = 32;
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_LVL_W = $clog2(RESQ_DEPTH + 1);

	// request codes on the input word
	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_COLLECT = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_COLLECT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [IDX_W-1:0]        neuron_index;
		logic signed [SUM_W-1:0] delta;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic signed [SUM_W-1:0] out_sum;
		logic                    last;
	} out_word_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        idx;
		logic signed [SUM_W-1:0] delta;
	} cmd_t;

	// saturating signed add
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		logic signed [SUM_W-1:0] r;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/tssa_ram.sv
module tssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/tssa_front.sv
module tssa_front import tssa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t req,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             keep;
	cmd_t             dec;

	// classify; unused request code is taken and dropped here
	always_comb begin
		dec.idx   = req.neuron_index;
		dec.delta = req.delta;
		dec.op    = OP_ADD;
		keep      = 1'b1;
		unique case (req.req_type)
			REQ_ADD:     dec.op = OP_ADD;
			REQ_COLLECT: dec.op = OP_COLLECT;
			REQ_CLEAR:   dec.op = OP_CLEAR;
			default:     keep   = 1'b0;
		endcase
	end

	assign full      = (count_q == CNT_W'(CMDQ_DEPTH));
	assign accept    = push && !full && keep;
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(accept) - CNT_W'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

endmodule

FILE: rtl/core/tssa_back.sv
module tssa_back import tssa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_pop,
	input  logic [RESQ_LVL_W-1:0] res_level,
	output logic                  res_push,
	output out_word_t             res_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t                  state_q;
	logic [NEURONS-1:0]      touched_q;
	logic [IDX_W-1:0]        ptr_q;
	logic                    hit_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    pend_v_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic signed [SUM_W-1:0] pend_sum_q;
	logic [IDX_W-1:0]        add_idx_q;
	logic signed [SUM_W-1:0] delta_q;

	logic [IDX_W-1:0]        raddr;
	logic [SUM_W-1:0]        rdata;
	logic                    we;
	logic signed [SUM_W-1:0] old_sum;
	logic signed [SUM_W-1:0] new_sum;
	logic                    issue_ok;

	tssa_ram #(
		.WIDTH(SUM_W),
		.DEPTH(NEURONS)
	) u_sums (
		.clk  (clk),
		.we   (we),
		.waddr(add_idx_q),
		.wdata(new_sum),
		.raddr(raddr),
		.rdata(rdata)
	);

	// an untouched entry reads as zero, so the store never needs a clearing pass
	assign old_sum = touched_q[add_idx_q] ? $signed(rdata) : '0;
	assign new_sum = sat_add(old_sum, delta_q);
	assign we      = (state_q == ST_ADD_WR);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign raddr   = (state_q == ST_IDLE) ? cmd.idx : ptr_q;

	// a touched entry is held back one step so the final one can carry last
	always_comb begin
		res_push = 1'b0;
		res_word = '{out_index: pend_idx_q, out_sum: pend_sum_q, last: 1'b0};
		priority if (hit_s1 && pend_v_q) begin
			res_push = 1'b1;
		end else if ((state_q == ST_FLUSH) && pend_v_q &&
				(res_level < RESQ_LVL_W'(RESQ_DEPTH))) begin
			res_push      = 1'b1;
			res_word.last = 1'b1;
		end
	end

	// a read issued now may push next cycle: keep a slot for it
	assign issue_ok = (res_level + RESQ_LVL_W'(res_push)) < RESQ_LVL_W'(RESQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			touched_q <= '0;
			ptr_q     <= '0;
			hit_s1    <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			hit_s1 <= (state_q == ST_SCAN) && issue_ok && touched_q[ptr_q];
			if (hit_s1) begin
				pend_v_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_ADD: state_q <= ST_ADD_WR;
							OP_COLLECT: begin
								ptr_q   <= '0;
								state_q <= ST_SCAN;
							end
							OP_CLEAR: touched_q <= '0;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD_WR: begin
					touched_q[add_idx_q] <= 1'b1;
					state_q              <= ST_IDLE;
				end
				ST_SCAN: begin
					if (issue_ok) begin
						if (ptr_q == IDX_W'(NEURONS - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				ST_DRAIN: state_q <= ST_FLUSH;
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (res_push) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			add_idx_q <= cmd.idx;
			delta_q   <= cmd.delta;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= ptr_q;
		end
		if (hit_s1) begin
			pend_idx_q <= idx_s1;
			pend_sum_q <= $signed(rdata);
		end
	end

endmodule

FILE: rtl/core/tssa_result_queue.sv
module tssa_result_queue import tssa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  out_word_t             push_word,
	input  logic                  pop,
	output logic                  empty,
	output out_word_t             head,
	output logic [RESQ_LVL_W-1:0] level
);

	localparam int PTR_W = $clog2(RESQ_DEPTH);

	out_word_t        entry_q [RESQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [RESQ_LVL_W-1:0] count_q;
	logic             take;

	assign empty = (count_q == '0);
	assign take  = pop && !empty;
	assign head  = entry_q[rd_ptr_q];
	assign level = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + RESQ_LVL_W'(push) - RESQ_LVL_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

FILE: rtl/core/touched_set_scatter_accumulator_core.sv
// channel   direction  handshake     payload
// request   in         push / full   req  (req_type, neuron_index, delta)
// result    out        empty / pop   rsp  (out_index, out_sum, last)
//
// an add in the back end is a sum ram read, then a saturating write
// a clear resets the touched marks; a collect walks all 64 entries, one ram read
// per cycle while the 4-deep result queue has room, then pushes the last hit
// a 2-deep request queue lets the front keep taking words while the back works
// reset clears the touched marks; sums of untouched neurons read as zero

module touched_set_scatter_accumulator_core import tssa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  req,
	output logic      empty,
	input  logic      pop,
	output out_word_t rsp
);

	logic                  cmd_valid;
	cmd_t                  cmd;
	logic                  cmd_pop;
	logic [RESQ_LVL_W-1:0] res_level;
	logic                  res_push;
	out_word_t             res_word;

	tssa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tssa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_level(res_level),
		.res_push (res_push),
		.res_word (res_word)
	);

	tssa_result_queue u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_word(res_word),
		.pop      (pop),
		.empty    (empty),
		.head     (rsp),
		.level    (res_level)
	);

endmodule

FILE: verif/touched_set_scatter_accumulator_core_tb.sv
module touched_set_scatter_accumulator_core_tb;
	import tssa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_VOID = 2'd3;
	localparam longint SUM_HI = 64'sd2147483647;
	localparam longint SUM_LO = -64'sd2147483648;
	localparam int RANDOM_ITEMS = 220;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT = 150;
	localparam int LONG_HOLD = 400;
	localparam int OWED_DEPTH = 4096;

	typedef struct packed {
		in_word_t  cmd;
		logic      typed;
		out_word_t lit;
	} dir_row_t;

	localparam out_word_t NO_LIT = '0;

	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd0,  32'h7fffffff}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd0,  32'h00000001}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b1, '{6'd0, 32'h7fffffff, 1'b1}},
		'{'{REQ_CLEAR,   6'd0,  32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd63, 32'h80000000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd63, 32'hffffffff}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b1, '{6'd63, 32'h80000000, 1'b1}},
		'{'{REQ_VOID,    6'd5,  32'h00000005}, 1'b0, NO_LIT},
		// fields of a collect are don't-care
		'{'{REQ_COLLECT, 6'd63, 32'hffffffff}, 1'b1, '{6'd63, 32'h80000000, 1'b1}},
		'{'{REQ_CLEAR,   6'd42, 32'h12345678}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd0,  32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b1, '{6'd0, 32'h00000000, 1'b1}},
		'{'{REQ_ADD,     6'd42, 32'h55555555}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd21, 32'haaaaaaaa}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd42, 32'h55555555}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd21, 32'haaaaaaaa}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd7,  32'hffff0000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd7,  32'h00008000}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_ADD,     6'd0,  32'h80000000}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd21, 32'h00000000}, 1'b0, NO_LIT},
		'{'{REQ_CLEAR,   6'd63, 32'hffffffff}, 1'b0, NO_LIT},
		'{'{REQ_COLLECT, 6'd0,  32'h00000000}, 1'b0, NO_LIT}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  req = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t rsp;

	touched_set_scatter_accumulator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	logic signed [SUM_W-1:0] neuron_sum [NEURONS];
	logic                    neuron_touched [NEURONS];
	// ring of words still owed by the block, in order
	out_word_t               owed_sums [OWED_DEPTH];
	int                      owed_wr = 0;
	int                      owed_rd = 0;

	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_asked = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void note_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void owe_word(input out_word_t w);
		owed_sums[owed_wr % OWED_DEPTH] = w;
		owed_wr++;
	endfunction

	// predicted effect of one accepted word on the window
	function automatic void accumulate_request(input in_word_t w);
		longint total;
		int hi;
		hi = -1;
		case (w.req_type)
			REQ_ADD: begin
				total = longint'(neuron_sum[w.neuron_index]) + longint'($signed(w.delta));
				if (total > SUM_HI) begin
					total = SUM_HI;
				end else if (total < SUM_LO) begin
					total = SUM_LO;
				end
				neuron_sum[w.neuron_index] = total[SUM_W-1:0];
				neuron_touched[w.neuron_index] = 1'b1;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NEURONS; i++) begin
					neuron_sum[i] = '0;
					neuron_touched[i] = 1'b0;
				end
			end
			REQ_COLLECT: begin
				for (int i = 0; i < NEURONS; i++) begin
					if (neuron_touched[i]) hi = i;
				end
				for (int i = 0; i < NEURONS; i++) begin
					if (neuron_touched[i]) begin
						owe_word('{IDX_W'(i), neuron_sum[i], i == hi});
					end
				end
			end
			default: ;
		endcase
	endfunction

	// sender bursts: no gap inside a burst, a random gap between bursts
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 24);
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
	endfunction

	function automatic logic [SUM_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3, 4: return $urandom;
			5, 6, 7: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return {($urandom_range(0, 1) ? 2'b10 : 2'b01), 30'($urandom)};
		endcase
	endfunction

	task automatic send_word(input in_word_t w, input logic typed, input out_word_t lit);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		req <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		if (typed) begin
			owe_word(lit);
		end else begin
			accumulate_request(w);
		end
	endtask

	// result side
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (owed_rd == owed_wr) begin
				note_error($sformatf("unexpected word: index %0d sum %h last %b",
					rsp.out_index, rsp.out_sum, rsp.last));
			end else begin
				want = owed_sums[owed_rd % OWED_DEPTH];
				owed_rd++;
				if (rsp.out_index !== want.out_index || rsp.out_sum !== want.out_sum ||
				    rsp.last !== want.last) begin
					note_error($sformatf(
						"word mismatch: want index %0d sum %h last %b, got index %0d sum %h last %b",
						want.out_index, want.out_sum, want.last,
						rsp.out_index, rsp.out_sum, rsp.last));
				end
			end
		end
	end

	initial begin : drain_side
		int hold_left;
		int mode;
		int phase;
		bit hold_taken;
		hold_left = 0;
		mode = 0;
		phase = 0;
		hold_taken = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_asked && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (phase % 64 == 0) mode = $urandom_range(0, 3);
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= phase[2];
				endcase
			end
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[touched_set_scatter_accumulator_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		int n_items;
		int n_adds;
		int base;
		int r;
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < NEURONS; i++) begin
			neuron_sum[i] = '0;
			neuron_touched[i] = 1'b0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_word(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].lit);
		end

		// long receiver hold while the sender keeps going
		hold_asked = 1'b1;
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_word('{REQ_VOID, IDX_W'($urandom), $urandom}, 1'b0, NO_LIT);
			end else if (r < 12) begin
				send_word('{REQ_CLEAR, IDX_W'($urandom), $urandom}, 1'b0, NO_LIT);
				n_items++;
			end else if (r < 16) begin
				send_word('{REQ_COLLECT, IDX_W'($urandom), $urandom}, 1'b0, NO_LIT);
				n_items++;
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					send_word('{REQ_CLEAR, IDX_W'($urandom), $urandom}, 1'b0, NO_LIT);
					n_items++;
				end
				if ($urandom_range(0, 7) == 0) begin
					// every neuron, descending, so the collect must reorder
					for (int k = NEURONS - 1; k >= 0; k--) begin
						send_word('{REQ_ADD, IDX_W'(k), pick_delta()}, 1'b0, NO_LIT);
						n_items++;
					end
				end else begin
					n_adds = $urandom_range(1, 12);
					base = $urandom_range(0, NEURONS - 1);
					for (int k = 0; k < n_adds; k++) begin
						// clustered indices give repeated hits and saturation
						idx = $urandom_range(0, 1) ? IDX_W'(base + $urandom_range(0, 3))
							: IDX_W'($urandom);
						send_word('{REQ_ADD, idx, pick_delta()}, 1'b0, NO_LIT);
						n_items++;
					end
				end
				send_word('{REQ_COLLECT, IDX_W'($urandom), $urandom}, 1'b0, NO_LIT);
				n_items++;
			end
		end
		@(negedge clk);
		push <= 1'b0;

		while (owed_rd != owed_wr) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("[touched_set_scatter_accumulator_core] OK");
		end else begin
			$display("[touched_set_scatter_accumulator_core] ERROR");
		end
		$finish;
	end

endmodule
